FILE: rtl/tnsel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnsel_pkg
// Field widths and the record type of the top-N selector.
// ----------------------------------------------------------------------------
package tnsel_pkg;

    localparam int WORD_W     = 64;
    localparam int NAME_WORDS = 6;
    localparam int TAIL_W     = 16;
    localparam int NAME_BITS  = WORD_W * NAME_WORDS + TAIL_W;
    localparam int ID_W       = 20;
    localparam int CNT_W      = 8;
    localparam int TOPC_W     = 7;

    localparam logic [TOPC_W-1:0] TOPC_RESET = 7'd4;

    // name holds character 0 in its top byte
    typedef struct packed {
        logic [NAME_BITS-1:0] name;
        logic [ID_W-1:0]      id;
        logic [CNT_W-1:0]     cnt;
    } t_rec;

endpackage

FILE: rtl/top_n_select_by_count_then_name.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_n_select_by_count_then_name
// Keeps the best MAX_KEPT records (count descending, name ascending, then
// arrival) in one synchronous memory and emits the top ones at end of set.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (i_in_valid / o_in_ready) takes one record per request.
//   Output channel (o_out_valid / i_out_ready) returns the ranked records
//   after a request flagged i_last_record; o_last_result marks the final one.
//   Config channel (i_cfg_valid / o_cfg_ready) writes top_count, always ready.
// Timing:
//   A record is inserted by walking the sorted memory from the tail: one
//   read-compare-write per cycle. The walk moves each kept record that ranks
//   below the new one down by one place.
//   The input is not ready again until the insertion is done.
//   After the last record, min(top_count, kept) results leave at one per cycle
//   through an output register; a stalled receiver holds the memory read
//   stream. The next set is accepted once all results are in the output reg.
// Reset:
//   Kept count cleared, top_count set to 4; memory contents are left as is.
// ----------------------------------------------------------------------------
module top_n_select_by_count_then_name #(
    parameter int MAX_KEPT   = 64,
    parameter int NAME_CHARS = 50
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tnsel_pkg::TOPC_W-1:0]     i_cfg_top_count,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [tnsel_pkg::WORD_W-1:0]     i_name_word_0,
    input  logic [tnsel_pkg::WORD_W-1:0]     i_name_word_1,
    input  logic [tnsel_pkg::WORD_W-1:0]     i_name_word_2,
    input  logic [tnsel_pkg::WORD_W-1:0]     i_name_word_3,
    input  logic [tnsel_pkg::WORD_W-1:0]     i_name_word_4,
    input  logic [tnsel_pkg::WORD_W-1:0]     i_name_word_5,
    input  logic [tnsel_pkg::TAIL_W-1:0]     i_name_tail,
    input  logic [tnsel_pkg::ID_W-1:0]       i_record_id,
    input  logic [tnsel_pkg::CNT_W-1:0]      i_event_count,
    input  logic                             i_last_record,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [tnsel_pkg::WORD_W-1:0]     o_out_name_word_0,
    output logic [tnsel_pkg::WORD_W-1:0]     o_out_name_word_1,
    output logic [tnsel_pkg::WORD_W-1:0]     o_out_name_word_2,
    output logic [tnsel_pkg::WORD_W-1:0]     o_out_name_word_3,
    output logic [tnsel_pkg::WORD_W-1:0]     o_out_name_word_4,
    output logic [tnsel_pkg::WORD_W-1:0]     o_out_name_word_5,
    output logic [tnsel_pkg::TAIL_W-1:0]     o_out_name_tail,
    output logic [tnsel_pkg::ID_W-1:0]       o_out_record_id,
    output logic [tnsel_pkg::CNT_W-1:0]      o_out_event_count,
    output logic                             o_last_result
);
    import tnsel_pkg::*;

    localparam int CW   = $clog2(MAX_KEPT + 1);
    localparam int AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int EW   = (CW > TOPC_W) ? CW : TOPC_W;
    localparam int NCHR = NAME_BITS / 8;

    localparam logic [CW-1:0] MaxK = CW'(MAX_KEPT);

    function automatic logic [NAME_BITS-1:0] name_mask();
        logic [NAME_BITS-1:0] m;
        m = '0;
        for (int c = 0; c < NCHR; c++) begin
            if (c < NAME_CHARS) m[NAME_BITS-1-8*c -: 8] = 8'hFF;
        end
        return m;
    endfunction

    localparam logic [NAME_BITS-1:0] NameMask = name_mask();

    typedef enum logic [1:0] {S_IDLE, S_INS, S_EMIT} t_state;

    t_state          r_state;
    logic [CW-1:0]   r_kept;
    logic [TOPC_W-1:0] r_topc;
    t_rec            r_new;
    logic            r_last;
    logic [CW-1:0]   r_hole;
    logic            r_cmp;
    logic [CW-1:0]   r_left;
    logic [AW-1:0]   r_eaddr;
    logic            r_pend;
    logic            r_pend_last;
    t_rec            r_out;
    logic            r_out_last;
    logic            r_out_valid;

    t_rec            mem [MAX_KEPT];
    t_rec            r_rdata;

    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    t_rec            mem_wdata;

    t_rec            in_rec;
    logic            in_acc;
    logic            above;
    logic [CW-1:0]   hole_m1;
    logic [CW-1:0]   n_kept;
    logic [EW-1:0]   topc_ext;
    logic [EW-1:0]   kept_ext;
    logic [CW-1:0]   n_emit;
    logic            out_load;
    logic            issue;

    assign in_rec.name = {i_name_word_0, i_name_word_1, i_name_word_2, i_name_word_3,
                          i_name_word_4, i_name_word_5, i_name_tail} & NameMask;
    assign in_rec.id   = i_record_id;
    assign in_rec.cnt  = i_event_count;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);

    // higher count first, then smaller name: invert name for one magnitude test
    assign above   = {r_new.cnt, ~r_new.name} > {r_rdata.cnt, ~r_rdata.name};
    assign hole_m1 = r_hole - 1'b1;

    assign n_kept   = (r_kept != MaxK) ? r_kept + 1'b1 : r_kept;
    assign topc_ext = EW'(r_topc);
    assign kept_ext = EW'(n_kept);
    assign n_emit   = (topc_ext < kept_ext) ? CW'(topc_ext) : n_kept;

    assign out_load = r_pend && (!r_out_valid || i_out_ready);
    assign issue    = (r_state == S_EMIT) && (r_left != '0) && (!r_pend || out_load);

    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = '0;
        mem_we    = 1'b0;
        mem_waddr = r_hole[AW-1:0];
        mem_wdata = r_new;
        case (r_state)
            S_IDLE: begin
                if (in_acc && r_kept != '0) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(r_kept - 1'b1);
                end
            end
            S_INS: begin
                mem_we = (r_hole != MaxK);
                if (r_cmp && above) begin
                    mem_wdata = r_rdata;
                    if (hole_m1 != '0) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(hole_m1 - 1'b1);
                    end
                end
            end
            S_EMIT: begin
                mem_re    = issue;
                mem_raddr = r_eaddr;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kept      <= '0;
            r_topc      <= TOPC_RESET;
            r_cmp       <= 1'b0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_topc <= i_cfg_top_count;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_new   <= in_rec;
                        r_last  <= i_last_record;
                        r_hole  <= r_kept;
                        r_cmp   <= (r_kept != '0);
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    if (r_cmp && above) begin
                        r_hole <= hole_m1;
                        r_cmp  <= (hole_m1 != '0);
                    end else begin
                        r_cmp <= 1'b0;
                        if (r_last) begin
                            r_kept  <= '0;
                            r_left  <= n_emit;
                            r_eaddr <= '0;
                            r_state <= (n_emit != '0) ? S_EMIT : S_IDLE;
                        end else begin
                            r_kept  <= n_kept;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_EMIT: begin
                    if (issue) begin
                        r_left      <= r_left - 1'b1;
                        r_eaddr     <= r_eaddr + 1'b1;
                        r_pend_last <= (r_left == CW'(1));
                    end
                    r_pend <= issue || (r_pend && !out_load);
                    if (r_left == '0 && !r_pend) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (out_load) begin
                r_out       <= r_rdata;
                r_out_last  <= r_pend_last;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_name_word_0 = r_out.name[NAME_BITS-1-WORD_W*0 -: WORD_W];
    assign o_out_name_word_1 = r_out.name[NAME_BITS-1-WORD_W*1 -: WORD_W];
    assign o_out_name_word_2 = r_out.name[NAME_BITS-1-WORD_W*2 -: WORD_W];
    assign o_out_name_word_3 = r_out.name[NAME_BITS-1-WORD_W*3 -: WORD_W];
    assign o_out_name_word_4 = r_out.name[NAME_BITS-1-WORD_W*4 -: WORD_W];
    assign o_out_name_word_5 = r_out.name[NAME_BITS-1-WORD_W*5 -: WORD_W];
    assign o_out_name_tail   = r_out.name[TAIL_W-1:0];
    assign o_out_record_id   = r_out.id;
    assign o_out_event_count = r_out.cnt;
    assign o_last_result     = r_out_last;

endmodule
